### rtl/fdem_pkg.sv
// ----------------------------------------------------------------------------
// fdem_pkg
// Types and constants shared by the FAT32 directory record matcher modules.
// ----------------------------------------------------------------------------
package fdem_pkg;

  // Directory record layout and scan limits.
  localparam int unsigned REC_BYTES   = 32;
  localparam int unsigned MAX_RECORDS = 4096;
  localparam int unsigned MAX_NAME    = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DELETED = 8'hE5;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  // Register indexes on the configuration port (8-byte stride).
  typedef enum logic [2:0] {
    REG_NAME_LO  = 3'd0,
    REG_NAME_HI  = 3'd1,
    REG_NAME_LEN = 3'd2,
    REG_LBA_BASE = 3'd3,
    REG_SPC      = 3'd4
  } fdem_reg_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_DELETED    = 3'd0,
    ST_NO_MATCH   = 3'd1,
    ST_MATCH      = 3'd2,
    ST_END_OF_DIR = 3'd3,
    ST_BAD_ATTR   = 3'd4,
    ST_CLOSED     = 3'd5
  } fdem_status_t;

  // Configuration register set.
  typedef struct packed {
    logic [63:0] target_name_lo;
    logic [31:0] target_name_hi;
    logic [3:0]  target_name_len;
    logic [31:0] clusters_lba_base;
    logic [7:0]  cluster_sectors;
  } fdem_cfg_t;

  // One input directory record.
  typedef struct packed {
    logic        start_scan;
    logic [63:0] name_base;
    logic [23:0] name_ext;
    logic [7:0]  attributes;
    logic [15:0] cluster_high;
    logic [15:0] cluster_low;
    logic [31:0] size_bytes;
  } fdem_rec_t;

  // One result item.
  typedef struct packed {
    fdem_status_t status;
    logic [31:0]  start_cluster;
    logic [31:0]  byte_count;
    logic         is_directory;
    logic [31:0]  first_sector;
    logic         cluster_invalid;
  } fdem_res_t;

  // Classified record passed from the front to the back.
  typedef struct packed {
    fdem_status_t status;
    logic [31:0]  start_cluster;
    logic [31:0]  byte_count;
    logic         is_directory;
    logic         cluster_invalid;
  } fdem_q_entry_t;

endpackage

### rtl/fdem_front.sv
// ----------------------------------------------------------------------------
// fdem_front
// Accepts directory records, tracks the scan state and classifies each record.
// ----------------------------------------------------------------------------
module fdem_front import fdem_pkg::*; #(
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  fdem_cfg_t     cfg,
  input  logic          rec_valid,
  input  fdem_rec_t     rec,
  input  logic          accept,
  output fdem_q_entry_t entry
);

  localparam int unsigned REC_PER_SECTOR = SECTOR_BYTES / REC_BYTES;
  localparam int unsigned LIM_RAW_W      = $clog2(REC_PER_SECTOR * 255 + 1);
  localparam int unsigned LIM_W          = (LIM_RAW_W > 13) ? LIM_RAW_W : 13;

  logic [11:0] record_index;
  logic [11:0] record_index_next;
  logic        scan_closed;
  logic        scan_closed_next;

  logic [LIM_W-1:0] lim_raw;
  logic [12:0]      limit;

  logic [7:0] bchar [MAX_NAME];
  logic [7:0] echar [3];
  logic [7:0] fmt   [MAX_NAME];
  logic [7:0] tgt   [MAX_NAME];
  logic [3:0] nb;
  logic [1:0] ne;
  logic       dot;
  logic [3:0] n_raw;
  logic [3:0] fmt_len;
  logic [3:0] tl_raw;
  logic [3:0] tgt_len;
  logic       name_match;

  // Records per cluster, capped at the largest directory cluster.
  assign lim_raw = LIM_W'(REC_PER_SECTOR) * LIM_W'(cfg.cluster_sectors);
  assign limit   = (lim_raw > LIM_W'(MAX_RECORDS)) ? 13'(MAX_RECORDS) : lim_raw[12:0];

  // Split the record name and the target into characters.
  always_comb begin
    for (int i = 0; i < int'(MAX_NAME); i++) begin
      bchar[i] = (i < 8) ? rec.name_base[(i % 8)*8 +: 8] : CHAR_NUL;
      tgt[i]   = (i < 8) ? cfg.target_name_lo[(i % 8)*8 +: 8]
                         : cfg.target_name_hi[(i % 4)*8 +: 8];
    end
    for (int i = 0; i < 3; i++) begin
      echar[i] = rec.name_ext[i*8 +: 8];
    end
  end

  // Lengths of the base and extension up to their first space.
  always_comb begin
    nb = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (bchar[i] == CHAR_SPACE) begin
        nb = 4'(i);
      end
    end
    ne = 2'd3;
    for (int i = 2; i >= 0; i--) begin
      if (echar[i] == CHAR_SPACE) begin
        ne = 2'(i);
      end
    end
    dot   = (echar[0] != CHAR_SPACE);
    n_raw = nb + {3'b0, dot} + {2'b0, ne};
  end

  // Assemble the 8.3 text: base, optional dot, extension.
  always_comb begin
    logic [3:0] k;
    k = 4'd0;
    for (int p = 0; p < int'(MAX_NAME); p++) begin
      k = 4'(p) - nb - {3'b0, dot};
      if (4'(p) < nb) begin
        fmt[p] = bchar[p];
      end else if (dot && (4'(p) == nb)) begin
        fmt[p] = CHAR_DOT;
      end else if (k < 4'd3) begin
        fmt[p] = echar[k[1:0]];
      end else begin
        fmt[p] = CHAR_NUL;
      end
    end
  end

  // Both texts end at their first zero character.
  always_comb begin
    tl_raw  = (cfg.target_name_len > 4'(MAX_NAME)) ? 4'(MAX_NAME) : cfg.target_name_len;
    fmt_len = n_raw;
    tgt_len = tl_raw;
    for (int p = int'(MAX_NAME) - 1; p >= 0; p--) begin
      if ((4'(p) < n_raw) && (fmt[p] == CHAR_NUL)) begin
        fmt_len = 4'(p);
      end
      if ((4'(p) < tl_raw) && (tgt[p] == CHAR_NUL)) begin
        tgt_len = 4'(p);
      end
    end
  end

  // Compare the texts position by position.
  always_comb begin
    name_match = (fmt_len == tgt_len);
    for (int p = 0; p < int'(MAX_NAME); p++) begin
      if ((4'(p) < fmt_len) && (fmt[p] != tgt[p])) begin
        name_match = 1'b0;
      end
    end
  end

  // Classify the record and work out the next scan state.
  always_comb begin
    logic [11:0] idx;
    logic        closed;
    logic [31:0] cluster;
    idx     = rec.start_scan ? 12'd0 : record_index;
    closed  = rec.start_scan ? 1'b0 : scan_closed;
    cluster = {rec.cluster_high, rec.cluster_low};

    entry             = '0;
    record_index_next = idx;
    scan_closed_next  = closed;

    if (closed || ({1'b0, idx} >= limit)) begin
      entry.status     = ST_CLOSED;
      scan_closed_next = 1'b1;
    end else begin
      if (bchar[0] == CHAR_NUL) begin
        entry.status     = ST_END_OF_DIR;
        scan_closed_next = 1'b1;
      end else if (bchar[0] == CHAR_DELETED) begin
        entry.status = ST_DELETED;
      end else if (rec.attributes[7:6] != 2'b00) begin
        entry.status     = ST_BAD_ATTR;
        scan_closed_next = 1'b1;
      end else if (name_match) begin
        entry.status          = ST_MATCH;
        entry.start_cluster   = cluster;
        entry.byte_count      = rec.size_bytes;
        entry.is_directory    = rec.attributes[4];
        entry.cluster_invalid = (cluster < 32'd2);
        scan_closed_next      = 1'b1;
      end else begin
        entry.status = ST_NO_MATCH;
      end
      // Advance to the next record, closing after the last one.
      if (!scan_closed_next) begin
        if (({1'b0, idx} + 13'd1) >= limit) begin
          scan_closed_next = 1'b1;
        end else begin
          record_index_next = idx + 12'd1;
        end
      end
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      record_index <= '0;
      scan_closed  <= 1'b0;
    end else if (accept && rec_valid) begin
      record_index <= record_index_next;
      scan_closed  <= scan_closed_next;
    end
  end

endmodule

### rtl/fdem_queue.sv
// ----------------------------------------------------------------------------
// fdem_queue
// Short queue of classified records between the front and the back.
// ----------------------------------------------------------------------------
module fdem_queue import fdem_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fdem_q_entry_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output fdem_q_entry_t head
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  fdem_q_entry_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/fdem_back.sv
// ----------------------------------------------------------------------------
// fdem_back
// Computes the first sector of a matched cluster and holds the result beat.
// ----------------------------------------------------------------------------
module fdem_back import fdem_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  fdem_cfg_t     cfg,
  input  logic          q_valid,
  input  fdem_q_entry_t q_head,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_stall,
  output fdem_res_t     res
);

  logic [31:0] sector_offset;
  logic [31:0] sector;

  // Take a new entry whenever the output register is free or being emptied.
  assign pop = q_valid && (!res_valid || !res_stall);

  // Sector address of the cluster, wrapping at 32 bits.
  assign sector_offset = (q_head.start_cluster - 32'd2) * {24'b0, cfg.cluster_sectors};
  assign sector = ((q_head.status == ST_MATCH) && !q_head.cluster_invalid)
                  ? cfg.clusters_lba_base + sector_offset : 32'd0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.status          <= q_head.status;
      res.start_cluster   <= q_head.start_cluster;
      res.byte_count      <= q_head.byte_count;
      res.is_directory    <= q_head.is_directory;
      res.first_sector    <= sector;
      res.cluster_invalid <= q_head.cluster_invalid;
    end
  end

endmodule

### rtl/fat32_dir_entry_matcher_top.sv
// ----------------------------------------------------------------------------
// fat32_dir_entry_matcher_top
// Scans FAT32 directory records of one cluster for a configured 8.3 name.
// ----------------------------------------------------------------------------
// Usage:
//   The record channel (rec_valid, rec_stall, rec) carries one 32-byte
//   directory record per beat; a beat with start_scan set opens a new
//   cluster scan. The result channel (res_valid, res_stall, res) returns
//   exactly one result beat per record, in order.
//   The APB port writes the target name, its length, the data area base
//   sector and the sectors per cluster; write it only while the block is idle.
//   An accepted record's classification is written into the queue and then
//   loaded into the output register, from which the result channel offers
//   it until it is taken. One record per cycle is sustained while the result
//   side is not stalled: the front classifies a record in its accept cycle,
//   the back computes the sector address (one 32 by 8 multiply and an add)
//   in the cycle it loads the output register.
//   A two-entry queue sits between front and back. When res_stall holds,
//   the output register keeps its beat, the queue fills and rec_stall rises
//   once it is full.
//   Reset clears the scan state, the queue and the output valid, and sets
//   the registers to their defaults (one sector per cluster, all else zero).
// ----------------------------------------------------------------------------
module fat32_dir_entry_matcher_top import fdem_pkg::*; #(
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Record channel
  input  logic        rec_valid,
  output logic        rec_stall,
  input  fdem_rec_t   rec,
  // Result channel
  output logic        res_valid,
  input  logic        res_stall,
  output fdem_res_t   res
);

  fdem_cfg_t     cfg;
  fdem_q_entry_t front_entry;
  fdem_q_entry_t q_head;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          rec_accept;
  logic          cfg_write;
  fdem_reg_t     reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = fdem_reg_t'(paddr[5:3]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_name_lo    <= '0;
      cfg.target_name_hi    <= '0;
      cfg.target_name_len   <= '0;
      cfg.clusters_lba_base <= '0;
      cfg.cluster_sectors   <= 8'd1;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_NAME_LO:  cfg.target_name_lo    <= pwdata;
        REG_NAME_HI:  cfg.target_name_hi    <= pwdata[31:0];
        REG_NAME_LEN: cfg.target_name_len   <= pwdata[3:0];
        REG_LBA_BASE: cfg.clusters_lba_base <= pwdata[31:0];
        REG_SPC:      cfg.cluster_sectors   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_sel)
      REG_NAME_LO:  prdata = cfg.target_name_lo;
      REG_NAME_HI:  prdata = {32'b0, cfg.target_name_hi};
      REG_NAME_LEN: prdata = {60'b0, cfg.target_name_len};
      REG_LBA_BASE: prdata = {32'b0, cfg.clusters_lba_base};
      REG_SPC:      prdata = {56'b0, cfg.cluster_sectors};
      default:      prdata = '0;
    endcase
  end

  // A record is taken whenever the queue has room.
  assign rec_stall  = q_full;
  assign rec_accept = rec_valid && !rec_stall;

  fdem_front #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rec_valid(rec_valid),
    .rec      (rec),
    .accept   (rec_accept),
    .entry    (front_entry)
  );

  fdem_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_accept),
    .push_data(front_entry),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head     (q_head)
  );

  fdem_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (q_pop),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

endmodule

### test/fdem_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdem_result_checker
// Watches the register port, the record channel and the result channel of the
// FAT32 directory record matcher. Keeps its own copy of the registers and the
// scan state, works out the result of every accepted record beat and compares
// each accepted result beat with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module fdem_result_checker import fdem_pkg::*; #(
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        rec_valid,
  input  logic        rec_stall,
  input  fdem_rec_t   rec,
  input  logic        res_valid,
  input  logic        res_stall,
  input  fdem_res_t   res,
  output int          mismatches,
  output int          outstanding
);

  // Shadow copies of the configuration registers.
  logic [63:0] name_lo;
  logic [31:0] name_hi;
  logic [3:0]  name_len;
  logic [31:0] lba_base;
  logic [7:0]  spc;

  // Scan state of the directory cluster being walked.
  int rec_idx;
  bit closed;

  fdem_res_t expected_results[$];

  // Classifies one directory record and advances the scan state.
  function automatic fdem_res_t classify_record(fdem_rec_t r);
    fdem_res_t   o;
    logic [95:0] fmt;
    logic [95:0] tgt;
    logic [7:0]  c;
    logic [31:0] first;
    int          n;
    int          nlen;
    int          tlen;
    int          lim;
    int          i;
    bit          stop;
    bit          hit;
    o   = '0;
    fmt = '0;
    n   = 0;

    // Format the 8.3 name: base up to the first space, a dot, then extension.
    stop = 1'b0;
    for (i = 0; i < 8; i++) begin
      c = r.name_base[8*i +: 8];
      if (c == CHAR_SPACE) stop = 1'b1;
      if (!stop) begin
        fmt[8*n +: 8] = c;
        n++;
      end
    end
    if (r.name_ext[7:0] != CHAR_SPACE) begin
      fmt[8*n +: 8] = CHAR_DOT;
      n++;
    end
    stop = 1'b0;
    for (i = 0; i < 3; i++) begin
      c = r.name_ext[8*i +: 8];
      if (c == CHAR_SPACE) stop = 1'b1;
      if (!stop) begin
        fmt[8*n +: 8] = c;
        n++;
      end
    end

    // Both texts end at their first zero character, like C strings.
    nlen = n;
    for (i = n - 1; i >= 0; i--) begin
      if (fmt[8*i +: 8] == CHAR_NUL) nlen = i;
    end
    tgt  = {name_hi, name_lo};
    tlen = (name_len > MAX_NAME) ? MAX_NAME : name_len;
    for (i = tlen - 1; i >= 0; i--) begin
      if (tgt[8*i +: 8] == CHAR_NUL) tlen = i;
    end
    hit = (nlen == tlen);
    for (i = 0; i < tlen; i++) begin
      if (fmt[8*i +: 8] != tgt[8*i +: 8]) hit = 1'b0;
    end

    lim = (SECTOR_BYTES / REC_BYTES) * spc;
    if (lim > MAX_RECORDS) lim = MAX_RECORDS;

    if (r.start_scan) begin
      rec_idx = 0;
      closed  = 1'b0;
    end

    // A closed scan, or one past the cluster's last record, answers closed.
    if (closed || rec_idx >= lim) begin
      closed   = 1'b1;
      o.status = ST_CLOSED;
      return o;
    end

    if (r.name_base[7:0] == CHAR_NUL) begin
      o.status = ST_END_OF_DIR;
      closed   = 1'b1;
    end else if (r.name_base[7:0] == CHAR_DELETED) begin
      o.status = ST_DELETED;
    end else if (r.attributes[7:6] != 2'b00) begin
      o.status = ST_BAD_ATTR;
      closed   = 1'b1;
    end else if (hit) begin
      o.status        = ST_MATCH;
      closed          = 1'b1;
      first           = {r.cluster_high, r.cluster_low};
      o.start_cluster = first;
      o.byte_count    = r.size_bytes;
      o.is_directory  = r.attributes[4];
      if (first < 32'd2) begin
        o.cluster_invalid = 1'b1;
      end else begin
        o.first_sector = lba_base + (first - 32'd2) * {24'd0, spc};
      end
    end else begin
      o.status = ST_NO_MATCH;
    end

    // The record at the last index closes the scan after it is handled.
    if (!closed) begin
      if (rec_idx + 1 >= lim) closed = 1'b1;
      else rec_idx = rec_idx + 1;
    end
    return o;
  endfunction

  task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, got %0h", field, want_v, got_v);
      mismatches++;
    end
  endtask

  // Sample all channels at the clock edge, results before new records.
  always @(posedge clk) begin : watch
    fdem_res_t want;
    if (rst) begin
      name_lo    = '0;
      name_hi    = '0;
      name_len   = '0;
      lba_base   = '0;
      spc        = 8'd1;
      rec_idx    = 0;
      closed     = 1'b0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (fdem_reg_t'(paddr[5:3]))
          REG_NAME_LO:  name_lo  = pwdata;
          REG_NAME_HI:  name_hi  = pwdata[31:0];
          REG_NAME_LEN: name_len = pwdata[3:0];
          REG_LBA_BASE: lba_base = pwdata[31:0];
          REG_SPC:      spc      = pwdata[7:0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no record outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(res.status));
          check_field("start_cluster", want.start_cluster, res.start_cluster);
          check_field("byte_count", want.byte_count, res.byte_count);
          check_field("is_directory", 32'(want.is_directory), 32'(res.is_directory));
          check_field("first_sector", want.first_sector, res.first_sector);
          check_field("cluster_invalid", 32'(want.cluster_invalid),
                      32'(res.cluster_invalid));
        end
      end
      if (rec_valid && !rec_stall) expected_results.push_back(classify_record(rec));
    end
    outstanding = expected_results.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the FAT32 directory record matcher. Programs target names and
// cluster geometry over the register port, then streams directed records and
// random directory clusters (hits, near misses, deleted, end and bad-attribute
// records, noise) under several sender and receiver idle patterns. A checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import fdem_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        rec_valid = 1'b0;
  logic        rec_stall;
  fdem_rec_t   rec = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  fdem_res_t   res;
  int          mismatches;
  int          outstanding;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  // Target text as programmed, character 0 in the lowest byte.
  logic [95:0] tgt_text;
  // Base and extension characters of the current target, for building hits.
  logic [63:0] want_base;
  logic [23:0] want_ext;
  int          want_bn;
  int          want_en;

  fat32_dir_entry_matcher_top dut (.*);

  fdem_result_checker chk (.*);

  always #5 clk = ~clk;

  // Receiver stalls at random.
  always @(posedge clk) res_stall <= ($urandom_range(99) < stall_pct);

  initial begin
    #2ms;
    $display("tb failed");
    $finish;
  end

  // A name character: never a space; a leading one is never zero or deleted.
  function automatic logic [7:0] rand_char(bit lead);
    logic [7:0] c;
    case ($urandom_range(3))
      0, 1:    c = 8'("A" + $urandom_range(25));
      2:       c = 8'("0" + $urandom_range(9));
      default: c = 8'($urandom);
    endcase
    if (c == CHAR_SPACE || (lead && (c == CHAR_NUL || c == CHAR_DELETED))) c = "_";
    return c;
  endfunction

  function automatic logic [63:0] spaced(string s);
    logic [63:0] v;
    int          i;
    for (i = 0; i < 8; i++) v[8*i +: 8] = (i < s.len()) ? s[i] : CHAR_SPACE;
    return v;
  endfunction

  function automatic fdem_rec_t entry(bit st, string b, string e, logic [7:0] attr,
                                      logic [31:0] clu, logic [31:0] sz);
    fdem_rec_t   r;
    logic [63:0] ev;
    ev           = spaced(e);
    r.start_scan = st;
    r.name_base  = spaced(b);
    r.name_ext   = ev[23:0];
    r.attributes = attr;
    {r.cluster_high, r.cluster_low} = clu;
    r.size_bytes = sz;
    return r;
  endfunction

  function automatic logic [31:0] rand_cluster();
    case ($urandom_range(19))
      0, 1, 2, 3: return 32'($urandom_range(2));
      4:          return 32'hFFFF_FFFF;
      default:    return $urandom;
    endcase
  endfunction

  // Record with the given name characters, padded with spaces; bytes past
  // the first padding space are sometimes junk, which the block ignores.
  function automatic fdem_rec_t dir_record(logic [63:0] b, int bn, logic [23:0] e, int en);
    fdem_rec_t r;
    int        i;
    r.start_scan = 1'b0;
    for (i = 0; i < 8; i++) begin
      if (i < bn) r.name_base[8*i +: 8] = b[8*i +: 8];
      else if (i == bn || $urandom_range(1)) r.name_base[8*i +: 8] = CHAR_SPACE;
      else r.name_base[8*i +: 8] = 8'($urandom);
    end
    for (i = 0; i < 3; i++) begin
      if (i < en) r.name_ext[8*i +: 8] = e[8*i +: 8];
      else if (i == en || $urandom_range(1)) r.name_ext[8*i +: 8] = CHAR_SPACE;
      else r.name_ext[8*i +: 8] = 8'($urandom);
    end
    r.attributes = {2'b00, 6'($urandom)};
    {r.cluster_high, r.cluster_low} = rand_cluster();
    r.size_bytes = $urandom;
    return r;
  endfunction

  task automatic pick_name(output logic [63:0] b, output int bn,
                           output logic [23:0] e, output int en);
    int i;
    b  = '0;
    e  = '0;
    bn = $urandom_range(1, 8);
    en = $urandom_range(0, 3);
    for (i = 0; i < bn; i++) b[8*i +: 8] = rand_char(i == 0);
    for (i = 0; i < en; i++) e[8*i +: 8] = rand_char(1'b0);
  endtask

  // Register write: setup cycle, then access until pready.
  task automatic write_reg(fdem_reg_t idx, logic [63:0] val);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_target(int len);
    write_reg(REG_NAME_LO, tgt_text[63:0]);
    write_reg(REG_NAME_HI, {32'd0, tgt_text[95:64]});
    write_reg(REG_NAME_LEN, 64'(len));
  endtask

  task automatic aim(string s, int len);
    int i;
    tgt_text = '0;
    for (i = 0; i < s.len() && i < 12; i++) tgt_text[8*i +: 8] = s[i];
    program_target(len);
  endtask

  task automatic geometry(logic [31:0] base, logic [7:0] spc);
    write_reg(REG_LBA_BASE, {32'd0, base});
    write_reg(REG_SPC, {56'd0, spc});
  endtask

  // Offers one record beat, with random idle cycles ahead of it.
  task automatic send_record(fdem_rec_t r);
    bit go;
    while ($urandom_range(99) < idle_pct) begin
      rec_valid <= 1'b0;
      @(posedge clk);
    end
    rec_valid <= 1'b1;
    rec       <= r;
    do begin
      @(negedge clk);
      go = !rec_stall;
      @(posedge clk);
    end while (!go);
  endtask

  // Waits until every result has come back, then lets the pipeline empty.
  task automatic settle();
    rec_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
  endtask

  initial begin : stimulus
    fdem_rec_t   r;
    int          ph;
    int          k;
    int          i;
    int          n;
    int          len;
    int          pos;
    int          cl_left;
    int          bn;
    int          en;
    logic [63:0] b;
    logic [23:0] e;
    logic [7:0]  spc;
    logic [31:0] base;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: every status, wrap of the sector address, low clusters.
    aim("FILE.TXT", 8);
    geometry(32'hFFFF_FFFF, 8'd255);
    send_record(entry(1'b1, "FILE", "TXT", 8'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_record(entry(1'b0, "FILE", "TXT", 8'h00, 32'd5, 32'd5));
    r = entry(1'b1, "XILE", "TXT", 8'hC0, 32'd9, 32'd9);
    r.name_base[7:0] = CHAR_DELETED;
    send_record(r);
    r = entry(1'b0, "", "", 8'h00, 32'd3, 32'd3);
    r.name_base = '1;
    r.name_ext  = '1;
    send_record(r);
    send_record(entry(1'b0, "FILE", "TXT", 8'h80, 32'd7, 32'd7));
    send_record(entry(1'b0, "FILE", "TXT", 8'h00, 32'd7, 32'd7));
    send_record(entry(1'b1, "OTHER", "BIN", 8'h40, 32'd8, 32'd8));
    r = entry(1'b1, "FILE", "TXT", 8'hC0, 32'd4, 32'd4);
    r.name_base[7:0] = CHAR_NUL;
    send_record(r);
    send_record(entry(1'b0, "FILE", "TXT", 8'h00, 32'd4, 32'd4));
    send_record(entry(1'b1, "FILE", "TXT", 8'h10, 32'd0, 32'd11));
    send_record(entry(1'b1, "FILE", "TXT", 8'h00, 32'd1, 32'd12));
    send_record(entry(1'b1, "FILE", "TXT", 8'h00, 32'd2, 32'd13));
    // Bytes after the first space in the base are ignored.
    r = entry(1'b1, "FILE", "TXT", 8'h01, 32'h0012_3456, 32'd123);
    r.name_base[63:40] = 24'h5A00FF;
    send_record(r);
    // A space in the first extension byte drops the dot and the extension.
    r = entry(1'b1, "FILE", "TXT", 8'h00, 32'd20, 32'd20);
    r.name_ext[7:0] = CHAR_SPACE;
    send_record(r);
    settle();

    // Full twelve-character name; a length above twelve counts as twelve.
    aim("ABCDEFGH.IJK", 15);
    geometry(32'd0, 8'd1);
    send_record(entry(1'b1, "ABCDEFGH", "IJK", 8'h00, 32'h0001_0000, 32'd7));
    send_record(entry(1'b1, "ABCDEFGH", "IJ", 8'h00, 32'd30, 32'd30));
    settle();

    aim("ABC", 3);
    r = entry(1'b1, "ABC", "XY", 8'h00, 32'd40, 32'd40);
    r.name_ext[7:0] = CHAR_SPACE;
    send_record(r);
    settle();

    // Zero characters end both the target and the formatted name.
    aim("AB", 5);
    send_record(entry(1'b1, "AB", "", 8'h00, 32'd50, 32'd50));
    r = entry(1'b1, "AB", "C", 8'h00, 32'd51, 32'd51);
    r.name_base[23:16] = CHAR_NUL;
    send_record(r);
    settle();

    // Empty target against an all-blank name.
    aim("", 0);
    send_record(entry(1'b1, "", "", 8'h00, 32'd60, 32'd60));
    settle();

    // No records fit in a cluster of zero sectors.
    geometry(32'd0, 8'd0);
    send_record(entry(1'b1, "", "", 8'h00, 32'd61, 32'd61));
    send_record(entry(1'b0, "X", "", 8'h00, 32'd62, 32'd62));
    settle();

    // Random directory clusters under each idle pattern.
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 49; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 6;  stall_pct = 6;  end
      endcase

      pick_name(want_base, want_bn, want_ext, want_en);
      tgt_text = '0;
      pos      = 0;
      for (i = 0; i < want_bn; i++) begin
        tgt_text[8*pos +: 8] = want_base[8*i +: 8];
        pos++;
      end
      if (want_en > 0) begin
        tgt_text[8*pos +: 8] = CHAR_DOT;
        pos++;
        for (i = 0; i < want_en; i++) begin
          tgt_text[8*pos +: 8] = want_ext[8*i +: 8];
          pos++;
        end
      end
      // Either a longer length with zero fill, or the exact one with junk after.
      if ($urandom_range(3) == 0) begin
        len = pos + $urandom_range(1, 3);
        if (len > 15) len = 15;
      end else begin
        len = pos;
        for (i = pos; i < 12; i++) tgt_text[8*i +: 8] = 8'($urandom);
      end
      program_target(len);

      case (ph)
        0:       spc = 8'd1;
        1:       spc = 8'd255;
        2:       spc = 8'd0;
        3:       spc = 8'd2;
        default: spc = $urandom_range(1) ? 8'($urandom_range(1, 3)) : 8'($urandom_range(1, 255));
      endcase
      if (ph == 0) base = 32'd0;
      else if (ph == 1) base = 32'hFFFF_FFFF;
      else base = $urandom;
      geometry(base, spc);

      n       = (ph == 2) ? 40 : 260;
      cl_left = 0;
      for (i = 0; i < n; i++) begin
        k = $urandom_range(99);
        if (k < 8) begin
          r = dir_record(want_base, want_bn, want_ext, want_en);
        end else if (k < 18) begin
          // Near miss: one bit flipped in the base characters or the extension field.
          r = dir_record(want_base, want_bn, want_ext, want_en);
          if ($urandom_range(1)) r.name_base[$urandom_range(8 * want_bn - 1)] ^= 1'b1;
          else r.name_ext[$urandom_range(23)] ^= 1'b1;
        end else begin
          pick_name(b, bn, e, en);
          r = dir_record(b, bn, e, en);
          if (k < 28) begin
            r.name_base[7:0] = CHAR_DELETED;
            r.attributes     = 8'($urandom);
          end else if (k < 32) begin
            r.name_base[7:0] = CHAR_NUL;
            r.attributes     = 8'($urandom);
          end else if (k < 36) begin
            r.attributes[7:6] = 2'($urandom_range(1, 3));
          end else if (k < 41) begin
            r.start_scan   = 1'($urandom);
            r.name_base    = {$urandom, $urandom};
            r.name_ext     = 24'($urandom);
            r.attributes   = 8'($urandom);
            r.cluster_high = 16'($urandom);
            r.cluster_low  = 16'($urandom);
            r.size_bytes   = $urandom;
          end else if (k < 44) begin
            r.name_base = {8{CHAR_SPACE}};
            r.name_ext  = {3{CHAR_SPACE}};
          end
        end
        // A new cluster opens once the current one is used up.
        if (cl_left == 0) begin
          cl_left      = $urandom_range(1, 24);
          r.start_scan = 1'b1;
        end
        cl_left--;
        send_record(r);
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### fat32_dir_entry_matcher_top.f
rtl/fdem_pkg.sv
rtl/fdem_front.sv
rtl/fdem_queue.sv
rtl/fdem_back.sv
rtl/fat32_dir_entry_matcher_top.sv
test/fdem_result_checker.sv
test/tb.sv
